FILE: rtl/tlb_pkg.sv
// ----------------------------------------------------------------------------
// tlb_pkg
// shared sizes and the command type for the lru address translator
// ----------------------------------------------------------------------------
package tlb_pkg;

  localparam int TlbEntries  = 16;
  localparam int FrameCount  = 128;
  localparam int ListEntries = 128;
  localparam int OffsetBits  = 8;

  localparam int TlbIdxW   = $clog2(TlbEntries);
  localparam int ListIdxW  = $clog2(ListEntries);
  localparam int ListCntW  = $clog2(ListEntries + 1);
  localparam int FrameW    = $clog2(FrameCount);
  localparam int FrameCntW = $clog2(FrameCount + 1);
  localparam int PageW     = 8;
  localparam int VaW       = 16;
  localparam int PaW       = 15;

  typedef struct packed {
    logic lookup;
    logic commit;
  } tlb_cmd_t;

endpackage

FILE: rtl/tlb_ctrl.sv
// ----------------------------------------------------------------------------
// tlb_ctrl
// sequences one translation: lookup cycle, commit cycle, result hold
// ----------------------------------------------------------------------------
module tlb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic                 out_fire,
  output logic                 busy,
  output logic                 out_valid,
  output tlb_pkg::tlb_cmd_t    cmd
);

  typedef enum logic [1:0] {S_IDLE, S_LOOKUP, S_COMMIT} state_t;
  state_t state;
  logic   commit_ok;

  // commit may land once the older result is gone or leaves this cycle
  assign commit_ok = !out_valid || out_fire;

  always_comb begin
    cmd.lookup = (state == S_LOOKUP);
    cmd.commit = (state == S_COMMIT) && commit_ok;
  end

  // accepts a new word once the previous one has committed
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_COMMIT && commit_ok) out_valid <= 1'b1;
      else if (out_fire) out_valid <= 1'b0;
      case (state)
        S_IDLE:   if (in_fire) state <= S_LOOKUP;
        S_LOOKUP: state <= S_COMMIT;
        S_COMMIT: if (commit_ok) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/tlb_datapath.sv
// ----------------------------------------------------------------------------
// tlb_datapath
// tlb cam, recency list cells, frame allocator and statistics counters
// ----------------------------------------------------------------------------
module tlb_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_fire,
  input  logic [tlb_pkg::VaW-1:0]       va,
  input  tlb_pkg::tlb_cmd_t             cmd,
  output logic [tlb_pkg::PaW-1:0]       phys_addr,
  output logic                          tlb_hit,
  output logic                          page_fault,
  output logic                          evict_valid,
  output logic [tlb_pkg::PageW-1:0]     evicted_page,
  output logic [31:0]                   translation_count,
  output logic [31:0]                   fault_count,
  output logic [31:0]                   hit_count
);

  localparam int TE = tlb_pkg::TlbEntries;
  localparam int LE = tlb_pkg::ListEntries;

  logic [TE-1:0]                        tlb_valid;
  logic [tlb_pkg::PageW-1:0]            tlb_tags   [TE];
  logic [tlb_pkg::FrameW-1:0]           tlb_frames [TE];
  logic [tlb_pkg::TlbIdxW-1:0]          tlb_fill_slot;

  logic [tlb_pkg::PageW-1:0]            list_page  [LE];
  logic [tlb_pkg::FrameW-1:0]           list_frame [LE];
  logic [tlb_pkg::ListCntW-1:0]         list_count;
  logic [tlb_pkg::FrameCntW-1:0]        frames_handed_out;

  logic [tlb_pkg::VaW-1:0]              va_q;
  logic [tlb_pkg::PageW-1:0]            page;
  logic [tlb_pkg::OffsetBits-1:0]       offset;

  // registered lookup results
  logic                                 r_hit;
  logic [tlb_pkg::FrameW-1:0]           r_tlb_frame;
  logic                                 r_found;
  logic [tlb_pkg::ListIdxW-1:0]         r_idx;

  assign page   = tlb_pkg::PageW'(va_q >> tlb_pkg::OffsetBits);
  assign offset = va_q[tlb_pkg::OffsetBits-1:0];

  // cam match over tlb
  logic [TE-1:0] tmatch;
  logic [tlb_pkg::FrameW-1:0] tframe;
  always_comb begin
    tframe = '0;
    for (int i = 0; i < TE; i++) begin
      tmatch[i] = tlb_valid[i] && (tlb_tags[i] == page);
      if (tmatch[i]) tframe = tframe | tlb_frames[i];
    end
  end

  // cam match over list cells; priority picks the front-most
  logic [LE-1:0] lmatch;
  logic [tlb_pkg::ListIdxW-1:0] lidx;
  always_comb begin
    lidx = '0;
    for (int i = LE - 1; i >= 0; i--) begin
      lmatch[i] = (tlb_pkg::ListCntW'(i) < list_count) && (list_page[i] == page);
      if (lmatch[i]) lidx = tlb_pkg::ListIdxW'(i);
    end
  end

  // fault path decisions
  logic                               room;
  logic [tlb_pkg::ListIdxW-1:0]       tail_idx;
  logic [tlb_pkg::FrameW-1:0]         new_frame;
  logic [tlb_pkg::ListIdxW-1:0]       mv_idx;
  logic [tlb_pkg::FrameW-1:0]         res_frame;
  logic                               fault_c, evict_c;
  always_comb begin
    room     = (frames_handed_out < tlb_pkg::FrameCntW'(tlb_pkg::FrameCount)) &&
               (list_count < tlb_pkg::ListCntW'(LE));
    tail_idx = tlb_pkg::ListIdxW'(list_count - tlb_pkg::ListCntW'(1));
    fault_c  = !r_hit && !r_found;
    evict_c  = fault_c && !room && (list_count != '0);
    if (room) new_frame = tlb_pkg::FrameW'(frames_handed_out);
    else if (list_count != '0) new_frame = list_frame[tail_idx];
    else new_frame = '0;
    if (r_found) mv_idx = r_idx;
    else if (room) mv_idx = tlb_pkg::ListIdxW'(list_count);
    else if (list_count != '0) mv_idx = tail_idx;
    else mv_idx = '0;
    if (r_hit) res_frame = r_tlb_frame;
    else if (r_found) res_frame = list_frame[r_idx];
    else res_frame = new_frame;
  end

  // shift enables for move to front, from the registered lookup
  logic [LE-1:0] shift_en;
  always_comb begin
    for (int i = 0; i < LE; i++) shift_en[i] = (tlb_pkg::ListIdxW'(i) <= mv_idx);
  end

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == '1) ? v : v + 32'd1;
  endfunction

  always_ff @(posedge clk) begin
    if (in_fire) va_q <= va;
    if (cmd.lookup) begin
      r_hit       <= |tmatch;
      r_tlb_frame <= tframe;
      r_found     <= |lmatch;
      r_idx       <= lidx;
    end
    if (cmd.commit) begin
      phys_addr        <= tlb_pkg::PaW'({res_frame, offset});
      tlb_hit          <= r_hit;
      page_fault       <= fault_c;
      evict_valid      <= evict_c;
      evicted_page     <= evict_c ? list_page[tail_idx] : '0;
      if (!r_hit) begin
        for (int i = 1; i < LE; i++) begin
          if (shift_en[i]) begin
            list_page[i]  <= list_page[i-1];
            list_frame[i] <= list_frame[i-1];
          end
        end
        list_page[0]  <= page;
        list_frame[0] <= res_frame;
        tlb_tags[tlb_fill_slot]   <= page;
        tlb_frames[tlb_fill_slot] <= res_frame;
      end
    end
    if (rst) begin
      tlb_valid         <= '0;
      tlb_fill_slot     <= '0;
      list_count        <= '0;
      frames_handed_out <= '0;
      translation_count <= '0;
      fault_count       <= '0;
      hit_count         <= '0;
    end else if (cmd.commit) begin
      translation_count <= sat_inc(translation_count);
      if (fault_c) fault_count <= sat_inc(fault_count);
      if (r_hit) hit_count <= sat_inc(hit_count);
      if (!r_hit) begin
        // evicted page leaves the tlb before the refill lands
        for (int i = 0; i < TE; i++) begin
          if (evict_c && tlb_valid[i] && tlb_tags[i] == list_page[tail_idx])
            tlb_valid[i] <= 1'b0;
        end
        tlb_valid[tlb_fill_slot] <= 1'b1;
        tlb_fill_slot <= (tlb_fill_slot == tlb_pkg::TlbIdxW'(TE - 1)) ? '0
                         : tlb_fill_slot + tlb_pkg::TlbIdxW'(1);
        if (fault_c && room) begin
          frames_handed_out <= frames_handed_out + tlb_pkg::FrameCntW'(1);
          list_count        <= list_count + tlb_pkg::ListCntW'(1);
        end else if (fault_c && list_count == '0) begin
          list_count <= tlb_pkg::ListCntW'(1);
        end
      end
    end
  end

endmodule

FILE: rtl/tlb_lru_address_translator.sv
// ----------------------------------------------------------------------------
// tlb_lru_address_translator
// virtual to physical translation with fifo-refilled tlb and lru page list
// ----------------------------------------------------------------------------
// an accepted word passes a lookup state and a commit state before its result is valid
// a new word is taken only once the previous one has committed
// a result waiting at the output holds back the commit of the next word, not its input
// the list cells do their parallel match in lookup and their move-to-front shift in commit
// reset: synchronous, clears tlb valid bits, list count, frame allocator, counters
module tlb_lru_address_translator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // virtual_address[15:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // phys_addr[14:0], pad
  output logic [106:0] m_tuser   // tlb_hit, page_fault, evict_valid, evicted_page[7:0],
                                 // translation_count[31:0], fault_count[31:0], hit_count[31:0]
);

  tlb_pkg::tlb_cmd_t    cmd;
  logic busy, in_fire, out_fire;
  logic [14:0] pa;
  logic hit, fault, ev;
  logic [7:0] evp;
  logic [31:0] tc, fc, hc;

  assign s_tready = !busy;
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  tlb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_fire(out_fire),
    .busy(busy), .out_valid(m_tvalid), .cmd(cmd)
  );

  tlb_datapath u_dp (
    .clk(clk), .rst(rst), .in_fire(in_fire), .va(s_tdata), .cmd(cmd),
    .phys_addr(pa), .tlb_hit(hit), .page_fault(fault),
    .evict_valid(ev), .evicted_page(evp), .translation_count(tc),
    .fault_count(fc), .hit_count(hc)
  );

  assign m_tdata = {1'b0, pa};
  assign m_tuser = {hc, fc, tc, evp, ev, fault, hit};

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives virtual addresses into the lru address translator and checks every
// translated word against a behavioral model of the tlb and page list
// ----------------------------------------------------------------------------

class translation_board;
  bit [8:0]  tlb_tag [tlb_pkg::TlbEntries];   // valid, page
  bit [6:0]  tlb_frm [tlb_pkg::TlbEntries];
  int        fill_slot;
  bit [7:0]  lru_page [tlb_pkg::ListEntries];
  bit [6:0]  lru_frame [tlb_pkg::ListEntries];
  int        lru_count;
  int        frames_given;
  bit [31:0] n_trans, n_fault, n_hit;
  bit [106:0] want_user [$];
  bit [14:0]  want_pa [$];
  int         errors;

  function new();
    foreach (tlb_tag[i]) tlb_tag[i] = '0;
    fill_slot = 0; lru_count = 0; frames_given = 0;
    n_trans = 0; n_fault = 0; n_hit = 0; errors = 0;
  endfunction

  function bit [31:0] sat_up(bit [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function void note_address(bit [15:0] va);
    bit [7:0] page;
    bit [6:0] frame;
    bit hit, fault, ev;
    bit [7:0] ev_page;
    int idx, pos;
    page = va[15:8];
    frame = 0; hit = 0; fault = 0; ev = 0; ev_page = 0; idx = -1;
    for (int i = 0; i < tlb_pkg::TlbEntries; i++)
      if (!hit && tlb_tag[i][8] && tlb_tag[i][7:0] == page) begin
        hit = 1; frame = tlb_frm[i];
      end
    if (!hit) begin
      for (int i = 0; i < lru_count; i++)
        if (idx < 0 && lru_page[i] == page) idx = i;
      if (idx >= 0) begin
        frame = lru_frame[idx];
        pos = idx;
      end else begin
        fault = 1;
        if (frames_given < tlb_pkg::FrameCount && lru_count < tlb_pkg::ListEntries) begin
          frame = frames_given[6:0];
          frames_given++;
          lru_count++;
        end else begin
          ev = 1;
          ev_page = lru_page[lru_count-1];
          frame = lru_frame[lru_count-1];
          // drop stale tlb mappings of the evicted page
          for (int i = 0; i < tlb_pkg::TlbEntries; i++)
            if (tlb_tag[i][8] && tlb_tag[i][7:0] == ev_page) tlb_tag[i][8] = 0;
        end
        pos = lru_count - 1;
      end
      for (int i = pos; i > 0; i--) begin
        lru_page[i] = lru_page[i-1]; lru_frame[i] = lru_frame[i-1];
      end
      lru_page[0] = page; lru_frame[0] = frame;
      tlb_tag[fill_slot] = {1'b1, page};
      tlb_frm[fill_slot] = frame;
      fill_slot = (fill_slot + 1) % tlb_pkg::TlbEntries;
    end
    n_trans = sat_up(n_trans);
    if (fault) n_fault = sat_up(n_fault);
    if (hit) n_hit = sat_up(n_hit);
    want_pa.push_back({frame, va[7:0]});
    want_user.push_back({n_hit, n_fault, n_trans, ev_page, ev, fault, hit});
  endfunction

  task report(string what, longint got, longint exp);
    $display("error: %s got %0h expected %0h", what, got, exp);
    errors++;
  endtask

  task check_word(bit [15:0] data, bit [106:0] user);
    bit [106:0] u;
    if (want_pa.size() == 0) begin
      report("unexpected word", data, 0);
      return;
    end
    u = want_user.pop_front();
    if (data[14:0] !== want_pa[0]) report("phys_addr", data[14:0], want_pa[0]);
    void'(want_pa.pop_front());
    if (user[0] !== u[0]) report("tlb_hit", user[0], u[0]);
    if (user[1] !== u[1]) report("page_fault", user[1], u[1]);
    if (user[2] !== u[2]) report("evict_valid", user[2], u[2]);
    if (user[10:3] !== u[10:3]) report("evicted_page", user[10:3], u[10:3]);
    if (user[42:11] !== u[42:11]) report("translation_count", user[42:11], u[42:11]);
    if (user[74:43] !== u[74:43]) report("fault_count", user[74:43], u[74:43]);
    if (user[106:75] !== u[106:75]) report("hit_count", user[106:75], u[106:75]);
  endtask
endclass

module testbench;
  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [15:0] s_tdata, m_tdata;
  logic [106:0] m_tuser;
  translation_board board;
  bit quiet;
  int idle_cycles;
  bit [15:0] addr_list [$];

  tlb_lru_address_translator DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    s_tvalid = 0; s_tdata = 0; m_tready = 0; rst = 1; quiet = 0;
    board = new();
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_word(m_tdata, m_tuser);
    if (!rst && s_tvalid && s_tready) board.note_address(s_tdata);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // receiver stalls in bursts
  initial begin
    int n;
    @(posedge clk);
    while (1) begin
      if (quiet || $urandom_range(0, 2) != 0) begin
        m_tready <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        m_tready <= 0;
        n = $urandom_range(1, 15);
        repeat (n) @(posedge clk);
      end
    end
  end

  task send_address(bit [15:0] va, bit allow_gap);
    if (allow_gap && !quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= va;
    do @(posedge clk); while (!s_tready);
  endtask

  task wait_drained();
    s_tvalid <= 0;
    @(posedge clk);
    while (board.want_pa.size() != 0) @(posedge clk);
  endtask

  function bit [15:0] pick_address(int mode);
    bit [7:0] pg;
    case (mode)
      0: pg = 8'($urandom_range(0, 11));          // tlb hits
      1: pg = 8'($urandom_range(0, 100));         // list hits, no eviction yet
      default: pg = 8'($urandom_range(0, 255));   // faults and evictions
    endcase
    return {pg, 8'($urandom)};
  endfunction

  initial begin
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, tlb hit, list hit after tlb wraps
    send_address(16'h0000, 0);
    send_address(16'h00FF, 0);
    send_address(16'hFFFF, 0);
    send_address(16'hFF00, 0);
    send_address(16'h5AA5, 0);
    send_address(16'hA55A, 0);
    for (int i = 1; i <= 16; i++) send_address({8'(i + 16), 8'(i)}, 0);
    send_address(16'h0012, 0);
    wait_drained();
    // fill past frame count so evictions start, with gaps and hits mixed in
    for (int i = 0; i < 400; i++) send_address(pick_address(i % 3), 1);
    wait_drained();
    for (int i = 0; i < 500; i++) send_address(pick_address($urandom_range(0, 2)), 1);
    quiet = 1;
    for (int i = 0; i < 230; i++) send_address(pick_address($urandom_range(0, 2)), 0);
    wait_drained();
    repeat (10) @(posedge clk);
    if (board.errors == 0) $display("tlb_lru_address_translator: match");
    else $display("tlb_lru_address_translator: mismatch");
    $finish;
  end

  initial begin
    wait (!rst);
    wait (idle_cycles >= 2000);
    $display("tlb_lru_address_translator: mismatch");
    $finish;
  end
endmodule
